FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define NZC_ASSERT(label, clk_sig, rst_n_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
        else $error("assertion failed");

`define NZC_ASSERT_NEVER(label, clk_sig, rst_n_sig, expr) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
        else $error("forbidden condition seen");

`else

`define NZC_ASSERT(label, clk_sig, rst_n_sig, prop)
`define NZC_ASSERT_NEVER(label, clk_sig, rst_n_sig, expr)

`endif

`endif

FILE: hw/rtl/nzc_pkg.sv
// Types, constants and helpers for the center zoom block.
// Used by nzc_axis_map and nearest_zoom_about_center.
package nzc_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int ZOOM_W  = 24;
    localparam int PIXEL_W = 32;

    // Config register indexes (paddr[3:2])
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INVERSE_ZOOM = 2'd2;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [ZOOM_W-1:0] RST_INVERSE_ZOOM = 24'd65536;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [PIXEL_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               in_frame;
    } out_word_t;

    // Dimension in use: zero reads as one, above the store limit saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > maxv)
            r = DIM_W'(maxv);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: hw/rtl/nzc_axis_map.sv
// One axis of the source coordinate map: multiply, recenter, round, range check.
// Three register stages; depends on nzc_pkg.
module nzc_axis_map
    import nzc_pkg::*;
#(
    parameter int MAX_DIM = MAX_WIDTH_DEF,
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
)
(
    input  logic               clk,
    input  logic [COORD_W-1:0] pos,
    input  logic [DIM_W-1:0]   dim,
    input  logic [ZOOM_W-1:0]  zoom,
    output logic [IW-1:0]      idx,
    output logic               ok
);

    // Work in half pixels: t = (2*pos - dim) * zoom + dim * 2^16,
    // the source coordinate times 2^17.
    localparam int OFF_W  = DIM_W + 2;
    localparam int PROD_W = OFF_W + ZOOM_W + 1;
    localparam int T_W    = PROD_W + 1;
    localparam int Q_W    = T_W - 17;

    logic signed [OFF_W-1:0]  off;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [T_W-1:0]    t_reg, t_next;
    logic                     neg;
    logic [T_W-1:0]           mag;
    logic [T_W-1:0]           rsum;
    logic [Q_W-1:0]           q;
    logic [IW-1:0]            idx_reg, idx_next;
    logic                     ok_reg, ok_next;

    always_comb
    begin
        off       = signed'({2'b00, pos, 1'b0}) - signed'({2'b00, dim});
        prod_next = PROD_W'(off) * PROD_W'(signed'({1'b0, zoom}));
        t_next    = T_W'(prod_reg) + T_W'(signed'({1'b0, dim, 16'h0000}));
    end

    // Round half away from zero on the magnitude
    always_comb
    begin
        neg  = t_reg[T_W-1];
        mag  = neg ? T_W'(-t_reg) : T_W'(t_reg);
        rsum = mag + T_W'(17'h10000);
        q    = rsum[T_W-1:17];
        if (neg)
        begin
            ok_next  = (q == '0);
            idx_next = '0;
        end
        else
        begin
            ok_next  = (q < Q_W'(dim));
            idx_next = IW'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        t_reg    <= t_next;
        idx_reg  <= idx_next;
        ok_reg   <= ok_next;
    end

    assign idx = idx_reg;
    assign ok  = ok_reg;

endmodule

FILE: hw/rtl/nearest_zoom_about_center.sv
// Top level: config registers, map pipeline, frame store and result stage.
// Depends on nzc_pkg, nzc_axis_map and assert_macros.svh.
//
//  channel   signals                                 moves
//  item      start / busy / item (in_word_t)         load or query word
//  result    result_valid / result (out_word_t)      one word per query
//  config    psel penable pwrite paddr pwdata prdata register access
//
// One item per clock; busy stays low. A query's result is formed after
// acceptance through one input stage, three map stages (multiply, recenter,
// round), then the frame store read. Loads write the store in the same stage
// where queries read it, so program order is kept with one port.
// rst_n clears control state only; the frame store is not cleared.
// The receiver cannot stall: each result is shown for one cycle.
`include "assert_macros.svh"

module nearest_zoom_about_center
    import nzc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    item,
    output logic        result_valid,
    output out_word_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [ZOOM_W-1:0] zoom_reg;
    logic [DIM_W-1:0]  dim_w, dim_h;
    logic              cfg_wr;

    in_word_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic     s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic     s5_vld_reg, s5_ok_reg;
    logic     accept;

    logic [XW-1:0] map_x;
    logic [YW-1:0] map_y;
    logic          ok_x, ok_y;

    logic [XW-1:0]      sel_x;
    logic [YW-1:0]      sel_y;
    logic               hit;
    logic [AW-1:0]      mem_addr;
    logic               mem_we, mem_re;
    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    logic               acc_query;
    logic               miss_out;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            zoom_reg   <= RST_INVERSE_ZOOM;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_INVERSE_ZOOM: zoom_reg   <= pwdata[ZOOM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            REG_INVERSE_ZOOM: prdata = 32'(zoom_reg);
            default:          prdata = '0;
        endcase
    end

    assign dim_w = clamp_dim(width_reg, MAX_WIDTH);
    assign dim_h = clamp_dim(height_reg, MAX_HEIGHT);

    // ---------------- pipeline ----------------
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg && (s4_reg.operation == OP_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= item;
        s2_reg    <= s1_reg;
        s3_reg    <= s2_reg;
        s4_reg    <= s3_reg;
        s5_ok_reg <= hit;
    end

    nzc_axis_map #(.MAX_DIM(MAX_WIDTH)) u_map_x (
        .clk  (clk),
        .pos  (s1_reg.pixel_x),
        .dim  (dim_w),
        .zoom (zoom_reg),
        .idx  (map_x),
        .ok   (ok_x)
    );

    nzc_axis_map #(.MAX_DIM(MAX_HEIGHT)) u_map_y (
        .clk  (clk),
        .pos  (s1_reg.pixel_y),
        .dim  (dim_h),
        .zoom (zoom_reg),
        .idx  (map_y),
        .ok   (ok_y)
    );

    // Loads address the store directly; writes beyond the store are dropped
    always_comb
    begin
        if (s4_reg.operation == OP_LOAD)
        begin
            sel_x = XW'(s4_reg.pixel_x);
            sel_y = YW'(s4_reg.pixel_y);
            hit   = (32'(s4_reg.pixel_x) < MAX_WIDTH) && (32'(s4_reg.pixel_y) < MAX_HEIGHT);
        end
        else
        begin
            sel_x = map_x;
            sel_y = map_y;
            hit   = ok_x && ok_y;
        end
        mem_addr = AW'(sel_y) * AW'(MAX_WIDTH) + AW'(sel_x);
        mem_we   = s4_vld_reg && (s4_reg.operation == OP_LOAD) && hit;
        mem_re   = s4_vld_reg && (s4_reg.operation == OP_QUERY) && hit;
    end

    // ---------------- frame store ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= s4_reg.pixel_in;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    assign result_valid     = s5_vld_reg;
    assign result.pixel_out = s5_ok_reg ? rd_data_reg : '0;
    assign result.in_frame  = s5_ok_reg;

    // ---------------- checks ----------------
    assign acc_query = accept && (item.operation == OP_QUERY);
    assign miss_out  = result_valid && !result.in_frame;

    `NZC_ASSERT(a_out_from_query, clk, rst_n, result_valid |-> $past(acc_query, 5))
    `NZC_ASSERT(a_zero_outside, clk, rst_n, miss_out |-> (result.pixel_out == '0))
    `NZC_ASSERT_NEVER(a_port_conflict, clk, rst_n, mem_we && mem_re)

endmodule

FILE: bench/tb_nearest_zoom_about_center.sv
// Self-checking testbench for nearest_zoom_about_center: loads, zoomed queries, APB config.
// Depends on nzc_pkg and the block's RTL; an in-bench predictor supplies the expected words.
`timescale 1ns / 100ps

module tb_nearest_zoom_about_center;
    import nzc_pkg::*;

    localparam int         CLK_PERIOD   = 12;
    localparam int         DRAIN_CYCLES = 10;     // five-stage query path plus margin
    localparam int         STORE_SIDE   = 256;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    in_word_t    item    = '0;
    logic        result_valid;
    out_word_t   result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_zoom_about_center DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor state
    logic [31:0]       shadow_store [0:STORE_SIDE*STORE_SIDE-1];
    bit                store_written [0:STORE_SIDE*STORE_SIDE-1];
    logic [DIM_W-1:0]  cfg_width  = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0]  cfg_height = RST_IMAGE_HEIGHT;
    logic [ZOOM_W-1:0] cfg_zoom   = RST_INVERSE_ZOOM;

    out_word_t pending_pixels [$];
    int        n_errors   = 0;
    int        n_reported = 0;
    bit        no_gaps    = 1'b0;

    function automatic int dim_in_use(input logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > STORE_SIDE)
            return STORE_SIDE;
        return int'(v);
    endfunction

    // One axis: offset from center, scaled (32 frac bits), recentered, rounded half away.
    function automatic bit map_axis(input logic [7:0] pos, input int dim, output int idx);
        longint center16;
        longint offset;
        longint scaled;
        longint mag;
        longint rounded;
        center16 = longint'(dim) * 32768;
        offset   = longint'(pos) * 65536 - center16;
        scaled   = offset * longint'(cfg_zoom) + center16 * 65536;
        mag      = (scaled < 0) ? -scaled : scaled;
        rounded  = (mag + 64'h8000_0000) >> 32;
        if (scaled < 0)
        begin
            idx = 0;
            return rounded == 0;    // (-0.5, 0) rounds to zero, still inside
        end
        idx = int'(rounded);
        return rounded < dim;
    endfunction

    function automatic bit locate_source(input logic [7:0] x, input logic [7:0] y,
                                         output int addr);
        int sx;
        int sy;
        bit okx;
        bit oky;
        okx  = map_axis(x, dim_in_use(cfg_width), sx);
        oky  = map_axis(y, dim_in_use(cfg_height), sy);
        addr = sy * STORE_SIDE + sx;
        return okx && oky;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_errors++;
        if (n_reported < 10)
        begin
            n_reported++;
            $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // result checker: receiver never stalls, every strobe is a word
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected result", 32'h0, result.pixel_out);
            else
            begin
                want = pending_pixels.pop_front();
                if (result.pixel_out !== want.pixel_out)
                    report_mismatch("pixel_out", want.pixel_out, result.pixel_out);
                if (result.in_frame !== want.in_frame)
                    report_mismatch("in_frame", 32'(want.in_frame), 32'(result.in_frame));
            end
        end
    end

    // random sender idle after an accepted word
    task automatic idle_gap();
        if (!no_gaps)
            while ($urandom_range(99) < 34)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
    endtask

    task automatic send_word(input in_word_t w);
        out_word_t want;
        bit        hit;
        int        addr;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        if (w.operation == OP_LOAD)
        begin
            shadow_store[{w.pixel_y, w.pixel_x}]  = w.pixel_in;
            store_written[{w.pixel_y, w.pixel_x}] = 1'b1;
        end
        else
        begin
            hit            = locate_source(w.pixel_x, w.pixel_y, addr);
            want.pixel_out = hit ? shadow_store[addr] : '0;
            want.in_frame  = hit;
            pending_pixels.push_back(want);
        end
        idle_gap();
    endtask

    task automatic load_pixel(input logic [7:0] x, input logic [7:0] y, input logic [31:0] p);
        in_word_t w;
        w.operation = OP_LOAD;
        w.pixel_x   = x;
        w.pixel_y   = y;
        w.pixel_in  = p;
        send_word(w);
    endtask

    // never read an unwritten entry: load the source first if needed
    task automatic query_pixel(input logic [7:0] x, input logic [7:0] y);
        in_word_t w;
        bit       hit;
        int       addr;
        hit = locate_source(x, y, addr);
        if (hit && !store_written[addr])
            load_pixel(addr[7:0], addr[15:8], $urandom());
        w.operation = OP_QUERY;
        w.pixel_x   = x;
        w.pixel_y   = y;
        w.pixel_in  = $urandom();
        send_word(w);
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // loads leave no result, so let the pipeline empty before touching registers
    task automatic wait_idle();
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [1:0] idx);
        logic [31:0] got;
        logic [31:0] want;
        apb_access(1'b0, idx, 32'h0, got);
        case (idx)
            REG_IMAGE_WIDTH:  want = 32'(cfg_width);
            REG_IMAGE_HEIGHT: want = 32'(cfg_height);
            default:          want = 32'(cfg_zoom);
        endcase
        if (got !== want)
            report_mismatch("register readback", want, got);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = value[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_INVERSE_ZOOM: cfg_zoom   = value[ZOOM_W-1:0];
            default:          ;
        endcase
        if (idx != REG_UNUSED)
            check_reg(idx);
    endtask

    task automatic configure(input logic [31:0] w, input logic [31:0] h, input logic [31:0] z);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_INVERSE_ZOOM, z);
    endtask

    task automatic test_reset_values();
        check_reg(REG_IMAGE_WIDTH);
        check_reg(REG_IMAGE_HEIGHT);
        check_reg(REG_INVERSE_ZOOM);
    endtask

    task automatic test_directed_cases();
        // identity zoom, corner and center pixels, extreme pixel values
        load_pixel(8'd0, 8'd0, 32'hFFFF_FFFF);
        load_pixel(8'd255, 8'd255, 32'h0000_0000);
        load_pixel(8'd128, 8'd128, 32'hA5C3_5A3C);
        query_pixel(8'd0, 8'd0);
        query_pixel(8'd255, 8'd255);
        query_pixel(8'd128, 8'd128);
        // zero width reads as one, height above limit saturates, zero zoom hits center
        configure(32'd0, 32'd511, 32'd0);
        query_pixel(8'd7, 8'd200);
        configure(32'd2, 32'd300, 32'd0);
        query_pixel(8'd255, 8'd0);
        // half-pixel tie rounds away from zero: 0.5 -> 1, and 2.0 falls off the edge
        configure(32'd2, 32'd256, 32'd32768);
        query_pixel(8'd0, 8'd5);
        query_pixel(8'd3, 8'd5);
        // slightly negative coordinate rounds to zero; exactly -0.5 is outside
        configure(32'd256, 32'd256, 32'd65600);
        query_pixel(8'd0, 8'd0);
        configure(32'd256, 32'd256, 32'd65792);
        query_pixel(8'd0, 8'd0);
        // largest and smallest nonzero zoom
        configure(32'd256, 32'd256, 32'h00FF_FFFF);
        query_pixel(8'd128, 8'd128);
        query_pixel(8'd129, 8'd128);
        configure(32'd256, 32'd256, 32'd1);
        query_pixel(8'd255, 8'd0);
        // query beyond the frame still goes through the mapping
        configure(32'd100, 32'd50, 32'd65536);
        query_pixel(8'd200, 8'd60);
        load_pixel(8'd250, 8'd250, 32'h1234_5678);    // outside W x H, still stored
        configure(32'd100, 32'd50, 32'd32768);
        query_pixel(8'd200, 8'd40);
        query_pixel(8'd130, 8'd30);
        configure(32'd256, 32'd256, 32'd65536);
        query_pixel(8'd250, 8'd250);
    endtask

    task automatic test_unknown_register();
        wait_idle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        test_reset_values();
        query_pixel(8'd250, 8'd250);
    endtask

    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 40)
                load_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), $urandom());
            else
                query_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic random_config();
        logic [31:0] dims [2];
        logic [31:0] z;
        for (int k = 0; k < 2; k++)
            case ($urandom_range(5))
                0:       dims[k] = 32'd0;
                1:       dims[k] = 32'd1;
                2:       dims[k] = 32'd256;
                3:       dims[k] = $urandom_range(257, 511);
                default: dims[k] = $urandom_range(2, 255);
            endcase
        case ($urandom_range(7))
            0:       z = 32'd0;
            1:       z = 32'd1;
            2:       z = 32'h00FF_FFFF;
            3:       z = 32'd65536;
            default: z = $urandom_range(16384, 262144);
        endcase
        configure(dims[0], dims[1], z);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                configure(32'd256, 32'd256, $urandom_range(32768, 131072));
            else
                random_config();
            no_gaps = (phase == 2);    // one long back-to-back stretch
            random_burst(180);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        configure($urandom_range(64, 256), $urandom_range(64, 256), $urandom_range(32768, 98304));
        random_burst(80);
        wait_results_done();
        random_burst(80);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed_cases();
        test_unknown_register();
        test_random_traffic();
        test_pause_until_drained();
        wait_idle();
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("FAIL");
        $finish;
    end

endmodule
